[design/f64oc_pkg.sv]
package f64oc_pkg;

    localparam int EXP_WIDTH  = 11;
    localparam int FRAC_WIDTH = 52;
    localparam int MAG_WIDTH  = EXP_WIDTH + FRAC_WIDTH;

    typedef logic [1:0] t_order;
    localparam t_order ORD_LESS = 2'd0;
    localparam t_order ORD_SAME = 2'd1;
    localparam t_order ORD_MORE = 2'd2;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_PARTIAL = 2'd0;
    localparam t_mode MODE_WEAK    = 2'd1;
    localparam t_mode MODE_TOTAL   = 2'd2;
    localparam t_mode MODE_SPARE   = 2'd3;

    typedef struct packed {
        logic                 neg;
        logic [MAG_WIDTH-1:0] mag;
        logic                 nan;
    } t_fp_view;

    function automatic t_fp_view decode(input logic [63:0] x);
        t_fp_view v;
        v.neg = x[MAG_WIDTH];
        v.mag = x[MAG_WIDTH-1:0];
        v.nan = (&x[MAG_WIDTH-1:FRAC_WIDTH]) && (|x[FRAC_WIDTH-1:0]);
        return v;
    endfunction

endpackage

[design/f64oc_compare.sv]
module f64oc_compare (
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [1:0]  o_code,
    output logic        o_equal
);

    f64oc_pkg::t_fp_view a, b;
    logic same_mag, a_lt_mag, both_zero, any_nan;
    logic [1:0] sm_code, ieee_code, rank_a, rank_b, weak_code;

    always_comb begin
        a = f64oc_pkg::decode(i_a);
        b = f64oc_pkg::decode(i_b);
        same_mag  = (a.mag == b.mag);
        a_lt_mag  = (a.mag < b.mag);
        both_zero = (a.mag == '0) && (b.mag == '0);
        any_nan   = a.nan || b.nan;

        // sign-magnitude order, reversed for negatives
        if (a.neg != b.neg) begin
            sm_code = a.neg ? f64oc_pkg::ORD_LESS : f64oc_pkg::ORD_MORE;
        end else if (same_mag) begin
            sm_code = f64oc_pkg::ORD_SAME;
        end else if (!a.neg) begin
            sm_code = a_lt_mag ? f64oc_pkg::ORD_LESS : f64oc_pkg::ORD_MORE;
        end else begin
            sm_code = a_lt_mag ? f64oc_pkg::ORD_MORE : f64oc_pkg::ORD_LESS;
        end

        ieee_code = (any_nan || both_zero) ? f64oc_pkg::ORD_SAME : sm_code;

        rank_a = !a.nan ? 2'd1 : (a.neg ? 2'd0 : 2'd2);
        rank_b = !b.nan ? 2'd1 : (b.neg ? 2'd0 : 2'd2);
        if (!any_nan) begin
            weak_code = ieee_code;
        end else if (rank_a < rank_b) begin
            weak_code = f64oc_pkg::ORD_LESS;
        end else if (rank_a > rank_b) begin
            weak_code = f64oc_pkg::ORD_MORE;
        end else begin
            weak_code = f64oc_pkg::ORD_SAME;
        end

        unique case (i_mode)
            f64oc_pkg::MODE_PARTIAL: o_code = ieee_code;
            f64oc_pkg::MODE_WEAK:    o_code = weak_code;
            f64oc_pkg::MODE_TOTAL:   o_code = sm_code;
            f64oc_pkg::MODE_SPARE:   o_code = sm_code;
            default:                 o_code = sm_code;
        endcase

        o_equal = !any_nan && (both_zero || (a.neg == b.neg && same_mag));
    end

endmodule

[design/float64_ordering_compare_core.sv]
// Compares two raw binary64 patterns under the mode held in the config register
// (0 partial IEEE, 1 weak with signed NaNs, 2 or 3 total order) and returns a
// three-way code and the IEEE equality flag. One operand pair is taken every
// cycle unless the output is stalled; a result appears in the cycle after its beat
// is accepted, set by the single result register. A full output register holds under
// back-pressure while the next beat can still enter whenever the result is being taken.
module float64_ordering_compare_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // operand_a [63:0], operand_b [127:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata   // order_code [1:0], ieee_equal [2], zero [7:3]
);

    logic [1:0] r_mode;
    logic       r_valid;
    logic [1:0] r_code, n_code;
    logic       r_equal, n_equal;

    f64oc_compare u_cmp (
        .i_mode (r_mode),
        .i_a    (s_axis_tdata[63:0]),
        .i_b    (s_axis_tdata[127:64]),
        .o_code (n_code),
        .o_equal(n_equal)
    );

    assign s_axis_tready = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= f64oc_pkg::MODE_PARTIAL;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_valid <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_code  <= n_code;
            r_equal <= n_equal;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'd0, r_equal, r_code};

endmodule

[design/f64oc_checker.sv]
module f64oc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [7:0]   m_axis_tdata
);

    // accepted beat always yields a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted beat gave no result");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("stalled with empty output");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad order code");

    // padding bits above the equality flag stay clear
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:3] == 5'd0)
        else $error("nonzero padding");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind float64_ordering_compare_core f64oc_checker u_f64oc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

[tb/tb.sv]
module tb;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;  // operand_a [63:0], operand_b [127:64]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;       // order_code [1:0], ieee_equal [2], zero [7:3]

    typedef struct packed {
        logic              has_exp;
        f64oc_pkg::t_order code;
        logic              eq;
    } t_dir_row;

    typedef struct {
        logic [63:0] a;
        logic [63:0] b;
        t_dir_row    want;
    } t_stim_row;

    localparam logic [63:0] PZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] NZERO = 64'h8000_0000_0000_0000;
    localparam logic [63:0] PINF  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NINF  = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] PQNAN = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] PSNAN = 64'h7FF0_0000_0000_0001;
    localparam logic [63:0] NQNAN = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE   = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] MONE  = 64'hBFF0_0000_0000_0000;
    localparam logic [63:0] PMAX  = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PDEN  = 64'h0000_0000_0000_0001;
    localparam int N_DIR = 14;
    localparam int N_RAND = 1450;
    localparam int WDOG_LIMIT = 20000;

    f64oc_pkg::t_mode cur_mode = f64oc_pkg::MODE_PARTIAL;
    t_dir_row  exp_q[$];
    t_stim_row dir_tab[N_DIR];
    int        n_err = 0;
    int        idle_cycles = 0;
    bit        rx_hold = 1'b0;
    bit        rx_stop = 1'b0;
    logic [7:0] last_out = '0;

    float64_ordering_compare_core u_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic f64oc_pkg::t_order sm_order(f64oc_pkg::t_fp_view a,
                                                   f64oc_pkg::t_fp_view b);
        if (a.neg != b.neg) return a.neg ? f64oc_pkg::ORD_LESS : f64oc_pkg::ORD_MORE;
        if (a.mag == b.mag) return f64oc_pkg::ORD_SAME;
        if (!a.neg) return (a.mag < b.mag) ? f64oc_pkg::ORD_LESS : f64oc_pkg::ORD_MORE;
        return (a.mag > b.mag) ? f64oc_pkg::ORD_LESS : f64oc_pkg::ORD_MORE;
    endfunction

    function automatic f64oc_pkg::t_order ieee_order(f64oc_pkg::t_fp_view a,
                                                     f64oc_pkg::t_fp_view b);
        if (a.nan || b.nan) return f64oc_pkg::ORD_SAME;
        if (a.mag == '0 && b.mag == '0) return f64oc_pkg::ORD_SAME;
        return sm_order(a, b);
    endfunction

    function automatic int nan_rank(f64oc_pkg::t_fp_view v);
        if (!v.nan) return 1;
        return v.neg ? 0 : 2;
    endfunction

    function automatic t_dir_row predict_compare(logic [63:0] ra, logic [63:0] rb,
                                                 f64oc_pkg::t_mode m);
        f64oc_pkg::t_fp_view a, b;
        t_dir_row r;
        int ka, kb;
        a.neg = ra[f64oc_pkg::MAG_WIDTH];
        a.mag = ra[f64oc_pkg::MAG_WIDTH-1:0];
        a.nan = (&ra[f64oc_pkg::MAG_WIDTH-1:f64oc_pkg::FRAC_WIDTH]) &&
                (|ra[f64oc_pkg::FRAC_WIDTH-1:0]);
        b.neg = rb[f64oc_pkg::MAG_WIDTH];
        b.mag = rb[f64oc_pkg::MAG_WIDTH-1:0];
        b.nan = (&rb[f64oc_pkg::MAG_WIDTH-1:f64oc_pkg::FRAC_WIDTH]) &&
                (|rb[f64oc_pkg::FRAC_WIDTH-1:0]);
        r.has_exp = 1'b1;
        r.eq = !a.nan && !b.nan &&
               ((a.mag == '0 && b.mag == '0) || (a.neg == b.neg && a.mag == b.mag));
        if (m == f64oc_pkg::MODE_PARTIAL) begin
            r.code = ieee_order(a, b);
        end else if (m == f64oc_pkg::MODE_WEAK) begin
            if (!a.nan && !b.nan) begin
                r.code = ieee_order(a, b);
            end else begin
                ka = nan_rank(a);
                kb = nan_rank(b);
                r.code = (ka < kb) ? f64oc_pkg::ORD_LESS :
                         ((ka > kb) ? f64oc_pkg::ORD_MORE : f64oc_pkg::ORD_SAME);
            end
        end else begin
            r.code = sm_order(a, b);
        end
        return r;
    endfunction

    function automatic logic [63:0] rand_operand();
        logic [63:0] x;
        x = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: x[62:52] = 11'h7FF;
            1: x[62:0] = '0;
            2: begin
                x[62:52] = 11'h7FF;
                x[51:0] = '0;
            end
            3: x[62:52] = '0;
            4: x[62:48] = {11'h3FF, 4'h0};
            default: ;
        endcase
        return x;
    endfunction

    // valid stays high across back-to-back beats, dropped only for a gap
    task automatic send_beat(logic [63:0] a, logic [63:0] b);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_mode(f64oc_pkg::t_mode m);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = m;
    endtask

    // predictions are queued as soon as the input beat is accepted
    always @(posedge i_clk) begin
        t_dir_row p;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            p = predict_compare(s_axis_tdata[63:0], s_axis_tdata[127:64], cur_mode);
            exp_q.push_back(p);
        end
    end

    always @(posedge i_clk) begin
        t_dir_row e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            last_out <= m_axis_tdata;
            if (exp_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                e = exp_q.pop_front();
                if (m_axis_tdata[1:0] !== e.code || m_axis_tdata[2] !== e.eq ||
                    m_axis_tdata[7:3] !== '0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: code exp %0d got %0d, eq exp %0d got %0d, pad %b",
                                 e.code, m_axis_tdata[1:0], e.eq, m_axis_tdata[2],
                                 m_axis_tdata[7:3]);
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold when requested
    initial begin
        int w;
        @(posedge i_rst_n);
        while (!rx_stop) begin
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (60) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (w != 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        f64oc_pkg::t_mode m;
        dir_tab[0]  = '{PZERO, NZERO, '{1'b1, f64oc_pkg::ORD_SAME, 1'b1}};
        dir_tab[1]  = '{ONE, MONE, '{1'b1, f64oc_pkg::ORD_MORE, 1'b0}};
        dir_tab[2]  = '{PQNAN, PQNAN, '{1'b1, f64oc_pkg::ORD_SAME, 1'b0}};
        dir_tab[3]  = '{NINF, PINF, '{1'b1, f64oc_pkg::ORD_LESS, 1'b0}};
        dir_tab[4]  = '{PINF, PINF, '{1'b1, f64oc_pkg::ORD_SAME, 1'b1}};
        dir_tab[5]  = '{PMAX, PINF, '{1'b0, f64oc_pkg::ORD_SAME, 1'b0}};
        dir_tab[6]  = '{PDEN, PZERO, '{1'b0, f64oc_pkg::ORD_SAME, 1'b0}};
        dir_tab[7]  = '{NQNAN, NINF, '{1'b0, f64oc_pkg::ORD_SAME, 1'b0}};
        dir_tab[8]  = '{PSNAN, PQNAN, '{1'b0, f64oc_pkg::ORD_SAME, 1'b0}};
        dir_tab[9]  = '{NQNAN, PSNAN, '{1'b0, f64oc_pkg::ORD_SAME, 1'b0}};
        dir_tab[10] = '{ONE, PQNAN, '{1'b0, f64oc_pkg::ORD_SAME, 1'b0}};
        dir_tab[11] = '{MONE, 64'hBFF0_0000_0000_0001, '{1'b0, f64oc_pkg::ORD_SAME, 1'b0}};
        dir_tab[12] = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, '{1'b0, f64oc_pkg::ORD_SAME, 1'b0}};
        dir_tab[13] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, '{1'b0, f64oc_pkg::ORD_SAME, 1'b0}};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset mode is partial; the first rows carry hand-read results
        for (int i = 0; i < N_DIR; i++) begin
            send_beat(dir_tab[i].a, dir_tab[i].b);
            if (dir_tab[i].want.has_exp) begin
                wait_drained();
                if (last_out[1:0] !== dir_tab[i].want.code ||
                    last_out[2] !== dir_tab[i].want.eq) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("row %0d: code exp %0d got %0d, eq exp %0d got %0d",
                                 i, dir_tab[i].want.code, last_out[1:0],
                                 dir_tab[i].want.eq, last_out[2]);
                end
            end
        end
        for (int md = f64oc_pkg::MODE_WEAK; md <= f64oc_pkg::MODE_SPARE; md++) begin
            set_mode(f64oc_pkg::t_mode'(md));
            for (int i = 0; i < N_DIR; i++) send_beat(dir_tab[i].a, dir_tab[i].b);
        end

        for (int i = 0; i < N_RAND; i++) begin
            if (i % 200 == 0) begin
                m = f64oc_pkg::t_mode'($urandom_range(0, 3));
                set_mode(m);
            end
            if (i == 300) rx_hold = 1'b1;
            if ($urandom_range(0, 4) == 0)
                send_beat(rand_operand(), rand_operand());
            else begin
                logic [63:0] a;
                a = rand_operand();
                case ($urandom_range(0, 2))
                    0: send_beat(a, a);
                    1: send_beat(a, a ^ 64'h8000_0000_0000_0000);
                    default: send_beat(a, a + 64'($urandom_range(0, 2)) - 64'd1);
                endcase
            end
        end
        wait_drained();
        rx_stop = 1'b1;
        if (n_err == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[sim.f]
design/f64oc_pkg.sv
design/f64oc_compare.sv
design/float64_ordering_compare_core.sv
design/f64oc_checker.sv
tb/tb.sv
